// ===== rtl/cpba_pkg.sv =====
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared widths, status codes and the word scan result for the page allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;
  localparam int DEF_NUM_PAGES = 1024;
  localparam int COUNT_W       = 11;
  localparam int PAGE_W        = 10;
  localparam int STATUS_W      = 3;
  localparam int RUN_W         = COUNT_W + 1;

  // free-run length saturates here, above any legal count
  localparam logic [COUNT_W-1:0] RUN_SAT = '1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FIRST_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RUN_FREE   = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic               hit;
    logic [BIT_W-1:0]   hit_bit;
    logic [COUNT_W-1:0] carry;
  } scan_res_t;

endpackage

// ===== rtl/cpba_word_scan.sv =====
// ----------------------------------------------------------------------------
// cpba_word_scan
// Finds the first bit of one map word at which a free run reaches the count.
// ----------------------------------------------------------------------------
module cpba_word_scan import cpba_pkg::*; (
  input  logic [WORD_BITS-1:0] used,
  input  logic [COUNT_W-1:0]   carry_in,
  input  logic [COUNT_W-1:0]   count,
  output scan_res_t            res
);

  logic [BIT_W-1:0]     last_pos [WORD_BITS];
  logic [WORD_BITS-1:0] any_pos;
  logic [WORD_BITS-1:0] hit_vec;

  // per bit: position of the nearest used bit at or below it
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      any_pos[i]  = 1'b0;
      last_pos[i] = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j <= i && used[j]) begin
          any_pos[i]  = 1'b1;
          last_pos[i] = BIT_W'(j);
        end
      end
    end
  end

  always_comb begin
    logic [RUN_W-1:0] run;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (used[i]) begin
        run = '0;
      end else if (any_pos[i]) begin
        run = RUN_W'(i) - RUN_W'(last_pos[i]);
      end else begin
        run = {1'b0, carry_in} + RUN_W'(i + 1);
      end
      hit_vec[i] = (run >= {1'b0, count});
    end
  end

  always_comb begin
    logic [RUN_W-1:0] sum;
    sum         = {1'b0, carry_in} + RUN_W'(WORD_BITS);
    res.hit     = |hit_vec;
    res.hit_bit = '0;
    // lowest hit wins
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        res.hit_bit = BIT_W'(i);
      end
    end
    if (any_pos[WORD_BITS-1]) begin
      res.carry = COUNT_W'(BIT_W'(WORD_BITS - 1) - last_pos[WORD_BITS-1]);
    end else if (sum > {1'b0, RUN_SAT}) begin
      res.carry = RUN_SAT;
    end else begin
      res.carry = sum[COUNT_W-1:0];
    end
  end

endmodule

// ===== rtl/contiguous_page_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator
// First-fit allocator of contiguous page runs over a word-wide usage map.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (tuser = kind, 0 allocate, 1 free;
//   tdata = start page, page count). Every request yields exactly one result
//   word on the m_ channel (status, base page).
//   The usage map lives in a memory of 32-page words, NUM_PAGES/32 rounded up
//   deep (32 at the default), with a registered read.
//   After reset a clearing pass writes every map word to free, one word per
//   cycle; s_tready stays low until it ends.
//   One request is worked on at a time. Allocate reads the map one word per
//   cycle from word 0 until the run is found, then rewrites the words the
//   run covers. Free reads the first page's word, checks the range word by
//   word, then clears it. A bad allocate, or a free whose start page is past
//   the pool, ends at once; a free with a free first page or a bad count
//   ends after the first word read. The result then passes to the output
//   register.
//   The output register holds a result while m_tready is low; the next
//   request is then taken but its result waits until the register frees.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator import cpba_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] start_page, [20:10] page_count, rest zero
  input  logic [0:0]  s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [2:0] status, [12:3] base_page, rest zero
);

  localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GW        = WA + BIT_W;
  localparam int EXT_W     = ((GW > COUNT_W) ? GW : COUNT_W) + 1;
  localparam int LAST_BITS = NUM_PAGES - (NUM_WORDS - 1) * WORD_BITS;

  localparam logic [WORD_BITS-1:0] PAD_MASK  = ~((32'd1 << LAST_BITS) - 32'd1);
  localparam logic [EXT_W-1:0]     NP_X      = EXT_W'(NUM_PAGES);
  localparam logic [WA-1:0]        LAST_WORD = WA'(NUM_WORDS - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FFIRST = 3'd3;
  localparam logic [2:0] S_FCHK   = 3'd4;
  localparam logic [2:0] S_MARK   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  function automatic logic [WORD_BITS-1:0] range_mask(
    input logic             is_lo,
    input logic [BIT_W-1:0] lo_bit,
    input logic             is_hi,
    input logic [BIT_W-1:0] hi_bit
  );
    logic [WORD_BITS-1:0] m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (!is_lo || (BIT_W'(i) >= lo_bit)) && (!is_hi || (BIT_W'(i) <= hi_bit));
    end
    return m;
  endfunction

  logic [WORD_BITS-1:0] map_mem [NUM_WORDS];

  logic [2:0]          state;
  logic [WA-1:0]       clr_addr;
  logic [PAGE_W-1:0]   req_first;
  logic [COUNT_W-1:0]  req_count;
  logic [GW-1:0]       lo;
  logic [GW-1:0]       hi;
  logic                mark_set;
  logic                iss_on;
  logic [WA-1:0]       iss_addr;
  logic [WA-1:0]       iss_last;
  logic                dat_vld;
  logic [WA-1:0]       dat_idx;
  logic [WORD_BITS-1:0] rd_data;
  logic [COUNT_W-1:0]  carry;
  logic [STATUS_W-1:0] res_status;
  logic [PAGE_W-1:0]   res_base;
  logic [STATUS_W-1:0] out_status;
  logic [PAGE_W-1:0]   out_base;

  logic                 rd_en;
  logic                 mem_we;
  logic [WA-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WA-1:0]        lo_word;
  logic [WA-1:0]        hi_word;
  logic [WORD_BITS-1:0] wmask;
  logic [WORD_BITS-1:0] scan_word;
  scan_res_t            scan_res;
  logic [EXT_W-1:0]     hit_base;
  logic [EXT_W-1:0]     in_first_x;
  logic [EXT_W-1:0]     in_count_x;
  logic [EXT_W-1:0]     first_x;
  logic [EXT_W-1:0]     end_x;
  logic [EXT_W-1:0]     last_x;
  logic [EXT_W-1:0]     lo_x;
  logic                 out_load;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {3'b000, out_base, out_status};
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign rd_en   = iss_on;
  assign lo_word = lo[GW-1:BIT_W];
  assign hi_word = hi[GW-1:BIT_W];
  assign wmask   = range_mask(dat_idx == lo_word, lo[BIT_W-1:0],
                              dat_idx == hi_word, hi[BIT_W-1:0]);

  // pages past the pool end look used to the search
  assign scan_word = rd_data | ((dat_idx == LAST_WORD) ? PAD_MASK : '0);

  cpba_word_scan u_scan (
    .used     (scan_word),
    .carry_in (carry),
    .count    (req_count),
    .res      (scan_res)
  );

  assign hit_base   = EXT_W'({dat_idx, scan_res.hit_bit}) + EXT_W'(1) - EXT_W'(req_count);
  assign in_first_x = EXT_W'(s_tdata[9:0]);
  assign in_count_x = EXT_W'(s_tdata[20:10]);
  assign first_x    = EXT_W'(req_first);
  assign end_x      = first_x + EXT_W'(req_count);
  assign last_x     = end_x - EXT_W'(1);
  assign lo_x       = EXT_W'(lo);

  assign mem_we = (state == S_CLEAR) || ((state == S_MARK) && dat_vld);
  assign mem_wa = (state == S_CLEAR) ? clr_addr : dat_idx;
  assign mem_wd = (state == S_CLEAR) ? '0 :
                  mark_set ? (rd_data | wmask) : (rd_data & ~wmask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= map_mem[iss_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      iss_on   <= 1'b0;
      dat_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid   <= 1'b1;
        out_status <= res_status;
        out_base   <= res_base;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      dat_vld <= rd_en;
      dat_idx <= iss_addr;
      if (rd_en) begin
        if (iss_addr == iss_last) begin
          iss_on <= 1'b0;
        end else begin
          iss_addr <= iss_addr + WA'(1);
        end
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WA'(1);
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_first <= s_tdata[9:0];
            req_count <= s_tdata[20:10];
            res_base  <= '0;
            if (s_tuser[0] == REQ_ALLOC) begin
              if (in_count_x == '0 || in_count_x > NP_X) begin
                res_status <= ST_INVALID;
                state      <= S_DONE;
              end else begin
                iss_addr <= '0;
                iss_last <= LAST_WORD;
                iss_on   <= 1'b1;
                carry    <= '0;
                mark_set <= 1'b1;
                state    <= S_SCAN;
              end
            end else begin
              if (in_first_x >= NP_X) begin
                res_status <= ST_INVALID;
                state      <= S_DONE;
              end else begin
                iss_addr <= in_first_x[GW-1:BIT_W];
                iss_last <= in_first_x[GW-1:BIT_W];
                iss_on   <= 1'b1;
                mark_set <= 1'b0;
                state    <= S_FFIRST;
              end
            end
          end
        end
        S_SCAN: begin
          if (dat_vld) begin
            if (scan_res.hit) begin
              // rewind to the run's first word and mark it
              lo       <= hit_base[GW-1:0];
              hi       <= {dat_idx, scan_res.hit_bit};
              iss_addr <= hit_base[GW-1:BIT_W];
              iss_last <= dat_idx;
              iss_on   <= 1'b1;
              dat_vld  <= 1'b0;
              state    <= S_MARK;
            end else if (dat_idx == LAST_WORD) begin
              res_status <= ST_NO_SPACE;
              state      <= S_DONE;
            end else begin
              carry <= scan_res.carry;
            end
          end
        end
        S_FFIRST: begin
          if (dat_vld) begin
            if (!rd_data[first_x[BIT_W-1:0]]) begin
              res_status <= ST_FIRST_FREE;
              state      <= S_DONE;
            end else if (req_count == '0 || end_x > NP_X) begin
              res_status <= ST_INVALID;
              state      <= S_DONE;
            end else begin
              lo       <= first_x[GW-1:0];
              hi       <= last_x[GW-1:0];
              iss_addr <= first_x[GW-1:BIT_W];
              iss_last <= last_x[GW-1:BIT_W];
              iss_on   <= 1'b1;
              dat_vld  <= 1'b0;
              state    <= S_FCHK;
            end
          end
        end
        S_FCHK: begin
          if (dat_vld) begin
            if ((rd_data & wmask) != wmask) begin
              res_status <= ST_RUN_FREE;
              iss_on     <= 1'b0;
              dat_vld    <= 1'b0;
              state      <= S_DONE;
            end else if (dat_idx == hi_word) begin
              iss_addr <= lo_word;
              iss_last <= hi_word;
              iss_on   <= 1'b1;
              dat_vld  <= 1'b0;
              state    <= S_MARK;
            end
          end
        end
        S_MARK: begin
          if (dat_vld && dat_idx == hi_word) begin
            res_status <= ST_OK;
            res_base   <= lo_x[PAGE_W-1:0];
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // drop reads still in flight once the search ends without a hit
      if (state == S_SCAN && dat_vld && !scan_res.hit && dat_idx == LAST_WORD) begin
        iss_on  <= 1'b0;
        dat_vld <= 1'b0;
      end
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("map written while idle");

  a_accept_drops_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in work");

  a_fail_base_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != ST_OK |-> out_base == '0)
    else $error("failed result carries a base page");

  a_data_follows_read: assert property (@(posedge clk) disable iff (rst)
    dat_vld |-> $past(rd_en))
    else $error("map data marked valid without a read");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MARK && mem_we |-> dat_idx >= lo_word && dat_idx <= hi_word)
    else $error("map word written outside the run");

endmodule

// ===== sim/tb_contiguous_page_bitmap_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_page_bitmap_allocator
// Drives allocate and free requests into the page allocator and checks every
// result word against a bit-accurate model of the page usage map. A directed
// table covers the corner cases, then random traffic allocates and frees runs.
// ----------------------------------------------------------------------------
module tb_contiguous_page_bitmap_allocator;
  import cpba_pkg::*;

  localparam int NUM_PAGES    = DEF_NUM_PAGES;
  localparam int RANDOM_ITEMS = 1550;
  localparam int QUIET_TAIL   = 150;
  localparam int LONG_HOLD    = 500;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 800000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   base;
  } alloc_result_t;

  typedef struct {
    logic                kind;
    int                  first;
    int                  count;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    int                  base;
  } plan_row_t;

  typedef struct {
    int base;
    int len;
  } run_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [9:0] start_page, [20:10] page_count
  logic [0:0]  s_tuser  = '0;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [2:0] status, [12:3] base_page

  logic [NUM_PAGES-1:0] page_used;
  alloc_result_t        expected_results[$];
  plan_row_t            plan[$];
  run_t                 live_runs[$];
  int                   mismatches  = 0;
  int                   sent_items  = 0;
  int                   words_in    = 0;
  int                   cycles      = 0;
  int                   sink_stall  = 0;
  int                   hold_left   = 0;
  bit                   hold_done   = 1'b0;

  contiguous_page_bitmap_allocator #(
    .NUM_PAGES(NUM_PAGES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // First-fit allocate / checked free over the usage map; updates the map.
  function automatic alloc_result_t apply_request(input logic kind,
                                                  input logic [PAGE_W-1:0] first,
                                                  input logic [COUNT_W-1:0] count);
    alloc_result_t res;
    int            run;
    res = '{status: ST_OK, base: '0};
    if (kind == REQ_ALLOC) begin
      if (count == 0 || int'(count) > NUM_PAGES) begin
        res.status = ST_INVALID;
        return res;
      end
      run = 0;
      for (int p = 0; p < NUM_PAGES; p++) begin
        if (page_used[p]) begin
          run = 0;
        end else begin
          run++;
          if (run == int'(count)) begin
            for (int q = p + 1 - run; q <= p; q++) page_used[q] = 1'b1;
            res.base = PAGE_W'(p + 1 - run);
            return res;
          end
        end
      end
      res.status = ST_NO_SPACE;
      return res;
    end
    if (int'(first) >= NUM_PAGES) begin
      res.status = ST_INVALID;
      return res;
    end
    // first-page check comes ahead of the count check
    if (!page_used[first]) begin
      res.status = ST_FIRST_FREE;
      return res;
    end
    if (count == 0 || int'(first) + int'(count) > NUM_PAGES) begin
      res.status = ST_INVALID;
      return res;
    end
    for (int p = int'(first); p < int'(first) + int'(count); p++) begin
      if (!page_used[p]) begin
        res.status = ST_RUN_FREE;
        return res;
      end
    end
    for (int p = int'(first); p < int'(first) + int'(count); p++) page_used[p] = 1'b0;
    res.base = first;
    return res;
  endfunction

  task automatic plan_row(input logic kind, input int first, input int count,
                          input bit typed, input logic [STATUS_W-1:0] status,
                          input int base);
    plan_row_t r;
    r = '{kind: kind, first: first, count: count, typed: typed, status: status,
          base: base};
    plan.push_back(r);
  endtask

  // Offer one word, wait for the handshake, log the expectation, maybe idle.
  task automatic send_request(input logic kind, input logic [PAGE_W-1:0] first,
                              input logic [COUNT_W-1:0] count, input bit typed,
                              input logic [STATUS_W-1:0] t_status,
                              input logic [PAGE_W-1:0] t_base,
                              output alloc_result_t pred);
    alloc_result_t want;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, count, first};
    do @(posedge clk); while (!s_tready);
    pred = apply_request(kind, first, count);
    want = pred;
    if (typed) want = '{status: t_status, base: t_base};
    expected_results.push_back(want);
    sent_items++;
    if (sent_items < RANDOM_ITEMS - QUIET_TAIL && (sent_items / 64) % 4 != 3 &&
        $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic random_request();
    int            pick;
    int            sub;
    int            idx;
    int            keep;
    int            count;
    run_t          r;
    alloc_result_t got;
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 85 && live_runs.size() == 0)) begin
      sub = $urandom_range(0, 99);
      if (sub < 70) count = $urandom_range(1, 16);
      else if (sub < 88) count = $urandom_range(17, 128);
      else if (sub < 95) count = $urandom_range(129, NUM_PAGES);
      else if (sub < 97) count = 0;
      else count = $urandom_range(NUM_PAGES + 1, 2047);
      send_request(REQ_ALLOC, PAGE_W'($urandom_range(0, NUM_PAGES - 1)), COUNT_W'(count),
                   1'b0, ST_OK, '0, got);
      if (got.status == ST_OK) begin
        r.base = int'(got.base);
        r.len  = count;
        live_runs.push_back(r);
      end
    end else if (pick < 85) begin
      idx = $urandom_range(0, live_runs.size() - 1);
      r   = live_runs[idx];
      sub = $urandom_range(0, 9);
      if (sub == 7 && r.len > 1) begin
        // free the tail, keep the head tracked
        keep = $urandom_range(1, r.len - 1);
        send_request(REQ_FREE, PAGE_W'(r.base + keep), COUNT_W'(r.len - keep), 1'b0,
                     ST_OK, '0, got);
        if (got.status == ST_OK) live_runs[idx].len = keep;
        else live_runs.delete(idx);
      end else begin
        // overlong free, or a free left tracked so it is freed twice later
        send_request(REQ_FREE, PAGE_W'(r.base),
                     COUNT_W'((sub == 8) ? r.len + 1 : r.len), 1'b0, ST_OK, '0, got);
        if (sub != 9) live_runs.delete(idx);
      end
    end else begin
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 16);
      send_request(1'($urandom_range(0, 1)), PAGE_W'($urandom_range(0, NUM_PAGES - 1)),
                   COUNT_W'(count), 1'b0, ST_OK, '0, got);
    end
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at cycle %0d: %s expected %0d got %0d",
               mismatches, cycles, what, want, got);
  endtask

  initial begin : stimulus
    alloc_result_t got;
    page_used = '0;
    // kind, start, count, typed, status, base
    plan_row(REQ_ALLOC, 0,    0,    1, ST_INVALID,    0);
    plan_row(REQ_ALLOC, 0,    1025, 1, ST_INVALID,    0);
    plan_row(REQ_ALLOC, 1023, 2047, 1, ST_INVALID,    0);
    plan_row(REQ_FREE,  0,    1,    1, ST_FIRST_FREE, 0);
    plan_row(REQ_FREE,  1023, 0,    1, ST_FIRST_FREE, 0);
    plan_row(REQ_ALLOC, 0,    1024, 1, ST_OK,         0);
    plan_row(REQ_ALLOC, 0,    1,    1, ST_NO_SPACE,   0);
    plan_row(REQ_FREE,  1023, 2,    1, ST_INVALID,    0);
    plan_row(REQ_FREE,  5,    0,    1, ST_INVALID,    0);
    plan_row(REQ_FREE,  0,    1024, 1, ST_OK,         0);
    plan_row(REQ_ALLOC, 1023, 1,    1, ST_OK,         0);
    plan_row(REQ_ALLOC, 0,    3,    0, ST_OK,         0);
    plan_row(REQ_FREE,  0,    1,    1, ST_OK,         0);
    plan_row(REQ_ALLOC, 0,    2,    0, ST_OK,         0);
    plan_row(REQ_FREE,  1,    6,    0, ST_OK,         0);
    plan_row(REQ_ALLOC, 0,    1018, 0, ST_OK,         0);
    plan_row(REQ_ALLOC, 0,    1,    0, ST_OK,         0);
    plan_row(REQ_ALLOC, 0,    1,    0, ST_OK,         0);
    plan_row(REQ_FREE,  1023, 1,    0, ST_OK,         0);
    plan_row(REQ_ALLOC, 0,    1,    0, ST_OK,         0);
    plan_row(REQ_FREE,  1023, 2047, 1, ST_INVALID,    0);
    plan_row(REQ_FREE,  0,    1024, 1, ST_OK,         0);
    plan_row(REQ_ALLOC, 682,  1024, 1, ST_OK,         0);
    plan_row(REQ_FREE,  0,    1024, 1, ST_OK,         0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_request(plan[i].kind, PAGE_W'(plan[i].first), COUNT_W'(plan[i].count),
                   plan[i].typed, plan[i].status, PAGE_W'(plan[i].base), got);
    repeat (RANDOM_ITEMS) random_request();
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result sink: random stall bursts, one long hold-off, calm stretches.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      m_tready  <= 1'b0;
    end else if (sink_stall > 0) begin
      m_tready   <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if (words_in < RANDOM_ITEMS - QUIET_TAIL && (words_in / 64) % 4 != 2 &&
                 $urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      sink_stall <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check
    alloc_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) words_in <= words_in + 1;
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result word, status", -1,
                        int'(m_tdata[STATUS_W-1:0]));
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[STATUS_W-1:0] !== want.status)
            flag_mismatch("status", int'(want.status), int'(m_tdata[STATUS_W-1:0]));
          if (m_tdata[STATUS_W +: PAGE_W] !== want.base)
            flag_mismatch("base_page", int'(want.base), int'(m_tdata[STATUS_W +: PAGE_W]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
